@@ src/wsfp_pkg.sv @@
// Package: shared types and constants of the WebSocket frame parser.
package wsfp_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [31:0] MAX_LEN_RESET = 32'd8000;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_NL    = 3'd1;
  localparam logic [2:0] KIND_CLOSE = 3'd2;
  localparam logic [2:0] KIND_PING  = 3'd3;
  localparam logic [2:0] KIND_PONG  = 3'd4;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_LEN,
    PH_L16A,
    PH_L16B,
    PH_L64,
    PH_KEY,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

@@ src/wsfp_core.sv @@
// Frame header walker, unmasking and event generation; one byte per accept.
module wsfp_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          max_frame_len,
  input  logic                 in_acc,
  input  logic [7:0]           byte_in,
  input  logic                 chunk_last,
  output wsfp_pkg::push_t      push
);

  wsfp_pkg::phase_t phase, phase_next;
  logic [62:0] frame_len, frame_len_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_index, mask_index_next;
  logic [3:0]  op, op_next;
  logic        drop, drop_next;
  logic        frag, frag_next;
  logic [2:0]  cnt, cnt_next;

  logic [3:0]  op_in;
  logic        fin;
  logic [62:0] len_dec;
  logic [7:0]  key_byte;
  logic        frame_done;

  assign op_in   = byte_in[3:0];
  assign fin     = byte_in[7];
  assign len_dec = frame_len - 63'd1;
  assign frame_done = (phase == wsfp_pkg::PH_KEY && cnt == 3'd3 && frame_len == '0) ||
                      (phase == wsfp_pkg::PH_DATA && len_dec == '0);

  always_comb begin
    case (mask_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_next      = phase;
    frame_len_next  = frame_len;
    mask_key_next   = mask_key;
    mask_index_next = mask_index;
    op_next         = op;
    drop_next       = drop;
    frag_next       = frag;
    cnt_next        = cnt;
    case (phase)
      wsfp_pkg::PH_HEAD: begin
        case (op_in)
          wsfp_pkg::OP_CONT: begin
            if (!frag) begin
              drop_next = 1'b1;
              op_next   = op_in;
            end else begin
              drop_next = 1'b0;
              op_next   = wsfp_pkg::OP_TEXT;
              frag_next = !fin;
            end
          end
          wsfp_pkg::OP_TEXT: begin
            op_next = op_in;
            if (frag) begin
              drop_next = 1'b1;
            end else begin
              drop_next = 1'b0;
              frag_next = !fin;
            end
          end
          wsfp_pkg::OP_CLOSE, wsfp_pkg::OP_PING, wsfp_pkg::OP_PONG: begin
            drop_next = 1'b1;
            op_next   = fin ? op_in : wsfp_pkg::OP_CONT;
          end
          default: begin
            drop_next = 1'b1;
            frag_next = 1'b0;
            op_next   = op_in;
          end
        endcase
        phase_next = wsfp_pkg::PH_LEN;
      end
      wsfp_pkg::PH_LEN: begin
        cnt_next = 3'd0;
        if (byte_in[6:0] == wsfp_pkg::LEN_EXT16) begin
          phase_next = wsfp_pkg::PH_L16A;
        end else if (byte_in[6:0] == wsfp_pkg::LEN_EXT64) begin
          phase_next = wsfp_pkg::PH_L64;
        end else begin
          frame_len_next = {56'd0, byte_in[6:0]};
          phase_next     = wsfp_pkg::PH_KEY;
        end
      end
      wsfp_pkg::PH_L16A: begin
        frame_len_next = {55'd0, byte_in};
        phase_next     = wsfp_pkg::PH_L16B;
      end
      wsfp_pkg::PH_L16B: begin
        frame_len_next = {frame_len[54:0], byte_in};
        phase_next     = wsfp_pkg::PH_KEY;
      end
      wsfp_pkg::PH_L64: begin
        if (cnt == 3'd0) begin
          frame_len_next = {56'd0, byte_in[6:0]};
        end else begin
          frame_len_next = {frame_len[54:0], byte_in};
        end
        if (cnt == 3'd7) begin
          cnt_next   = 3'd0;
          phase_next = wsfp_pkg::PH_KEY;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      wsfp_pkg::PH_KEY: begin
        if (cnt == 3'd0 && frame_len > {31'd0, max_frame_len}) begin
          drop_next = 1'b1;
          frag_next = 1'b0;
        end
        mask_key_next = {mask_key[23:0], byte_in};
        if (cnt == 3'd3) begin
          mask_index_next = 2'd0;
          cnt_next        = 3'd0;
          phase_next      = (frame_len != '0) ? wsfp_pkg::PH_DATA : wsfp_pkg::PH_HEAD;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      wsfp_pkg::PH_DATA: begin
        mask_index_next = mask_index + 2'd1;
        frame_len_next  = len_dec;
        if (len_dec == '0) begin
          phase_next = wsfp_pkg::PH_HEAD;
        end
      end
      default: begin
        phase_next = wsfp_pkg::PH_HEAD;
      end
    endcase
  end

  // results
  always_comb begin
    logic          has_a;
    wsfp_pkg::res_t a;
    logic          nl;
    has_a  = 1'b0;
    a.kind = wsfp_pkg::KIND_DATA;
    a.data = 8'd0;
    a.last = 1'b1;
    nl     = in_acc && chunk_last;
    if (in_acc && phase == wsfp_pkg::PH_DATA && !drop) begin
      has_a  = 1'b1;
      a.data = byte_in ^ key_byte;
    end else if (in_acc && frame_done) begin
      case (op)
        wsfp_pkg::OP_CLOSE: begin
          has_a  = 1'b1;
          a.kind = wsfp_pkg::KIND_CLOSE;
        end
        wsfp_pkg::OP_PING: begin
          has_a  = 1'b1;
          a.kind = wsfp_pkg::KIND_PING;
        end
        wsfp_pkg::OP_PONG: begin
          has_a  = 1'b1;
          a.kind = wsfp_pkg::KIND_PONG;
        end
        default: has_a = 1'b0;
      endcase
    end
    a.last       = !nl;
    push.cnt     = {1'b0, has_a} + {1'b0, nl};
    push.r1.kind = wsfp_pkg::KIND_NL;
    push.r1.data = wsfp_pkg::NEWLINE;
    push.r1.last = 1'b1;
    push.r0      = has_a ? a : push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= wsfp_pkg::PH_HEAD;
      frame_len  <= '0;
      mask_key   <= '0;
      mask_index <= '0;
      op         <= '0;
      drop       <= 1'b0;
      frag       <= 1'b0;
      cnt        <= '0;
    end else if (in_acc) begin
      phase      <= phase_next;
      frame_len  <= frame_len_next;
      mask_key   <= mask_key_next;
      mask_index <= mask_index_next;
      op         <= op_next;
      drop       <= drop_next;
      frag       <= frag_next;
      cnt        <= cnt_next;
    end
  end

  a_data_len: assert property (@(posedge clk) disable iff (rst)
    phase == wsfp_pkg::PH_DATA |-> frame_len != '0)
    else $error("data phase with zero remaining length");

  a_key_cnt: assert property (@(posedge clk) disable iff (rst)
    phase == wsfp_pkg::PH_KEY |-> cnt <= 3'd3)
    else $error("key byte counter out of range");

  a_pass_text: assert property (@(posedge clk) disable iff (rst)
    phase == wsfp_pkg::PH_DATA && !drop |-> op == wsfp_pkg::OP_TEXT)
    else $error("payload passed for a non-text frame");

endmodule

@@ src/websocket_frame_parser.sv @@
// Top level: WebSocket frame parser with result queue and config register.
//
// Input stream s_*: one raw received byte per word (s_tdata), s_tlast marks
// the last byte of a chunk and appends a newline result.
// Output stream m_*: one result per word. m_tuser is the result kind
// (0 payload, 1 newline, 2 send close reply, 3 send pong, 4 pong received),
// m_tdata the unmasked payload byte or newline (zero for events), m_tlast
// flags the final result caused by one input byte.
// Each input byte yields zero, one or two results.
// cfg_wen/cfg_wdata write max_frame_len (reset 8000); the user must write it
// only while the block is idle, the block itself does not enforce this.
// Results of a byte are registered in the result queue before they reach m_*.
// Throughput: one byte per cycle while s_tready is high; header, length, key
// and payload bytes are all handled in the cycle they arrive. The output is a
// 4-word result queue; s_tready is high while at least two queue slots are free.
// Reset: the parser returns to waiting for a frame header, the queue empties.
// A stalled receiver fills the queue and then holds s_tready low.
module websocket_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast,
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]                   max_frame_len;
  logic                          in_acc;
  logic                          pop;
  wsfp_pkg::push_t               push;
  wsfp_pkg::res_t                q [wsfp_pkg::QDEPTH];
  logic [wsfp_pkg::QAW-1:0]      wr_ptr, rd_ptr;
  logic [wsfp_pkg::QCW-1:0]      count, count_next;
  wsfp_pkg::res_t                head;

  assign s_tready = count <= wsfp_pkg::QCW'(wsfp_pkg::QDEPTH - 2);
  assign in_acc   = s_tvalid && s_tready;
  assign m_tvalid = count != '0;
  assign pop      = m_tvalid && m_tready;
  assign head     = q[rd_ptr];
  assign m_tdata  = head.data;
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;
  assign count_next = count + wsfp_pkg::QCW'(push.cnt) - wsfp_pkg::QCW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= wsfp_pkg::MAX_LEN_RESET;
    end else if (cfg_wen) begin
      max_frame_len <= cfg_wdata;
    end
  end

  wsfp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .max_frame_len (max_frame_len),
    .in_acc        (in_acc),
    .byte_in       (s_tdata),
    .chunk_last    (s_tlast),
    .push          (push)
  );

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q[wr_ptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      q[wr_ptr + wsfp_pkg::QAW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + wsfp_pkg::QAW'(push.cnt);
      rd_ptr <= rd_ptr + wsfp_pkg::QAW'(pop);
      count  <= count_next;
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    count <= wsfp_pkg::QCW'(wsfp_pkg::QDEPTH))
    else $error("result queue overflow");

  a_q_count: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count_next))
    else $error("queue count lost track");

  a_nl_push: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tlast |-> push.cnt != 2'd0 &&
      ((push.cnt == 2'd1 && push.r0.kind == wsfp_pkg::KIND_NL) ||
       (push.cnt == 2'd2 && push.r1.kind == wsfp_pkg::KIND_NL)))
    else $error("chunk end without newline result");

  a_no_push_idle: assert property (@(posedge clk) disable iff (rst)
    !in_acc |-> push.cnt == 2'd0)
    else $error("results pushed without an accepted word");

endmodule

@@ bench/wsfp_checker.sv @@
`timescale 1ns / 100ps
// Checker: predicts the parser's output words from the accepted input bytes and compares.
module wsfp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  wsfp_pkg::phase_t phase;
  int unsigned      sub_cnt;
  logic [62:0]      frame_len;
  logic [31:0]      mask_key;
  logic [1:0]       mask_idx;
  logic [3:0]       head_op;
  logic             data_ok;
  logic             in_frag;
  logic [31:0]      max_len;
  wsfp_pkg::res_t   expected_words[$];
  wsfp_pkg::res_t   want;
  int               shown;

  initial begin
    errors  = 0;
    pending = 0;
    shown   = 0;
  end

  task automatic add_word(input logic [2:0] k, input logic [7:0] d);
    wsfp_pkg::res_t r;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    expected_words.push_back(r);
  endtask

  task automatic close_frame();
    phase = wsfp_pkg::PH_HEAD;
    case (head_op)
      wsfp_pkg::OP_CLOSE: add_word(wsfp_pkg::KIND_CLOSE, 8'h00);
      wsfp_pkg::OP_PING:  add_word(wsfp_pkg::KIND_PING, 8'h00);
      wsfp_pkg::OP_PONG:  add_word(wsfp_pkg::KIND_PONG, 8'h00);
      default:  ;
    endcase
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic lst);
    int          base_n;
    int          sh;
    logic [3:0]  op;
    base_n = expected_words.size();
    case (phase)
      wsfp_pkg::PH_HEAD: begin
        op = b[3:0];
        case (op)
          wsfp_pkg::OP_CONT: begin
            if (!in_frag) begin
              data_ok = 1'b0;
            end else begin
              data_ok = 1'b1;
              op      = wsfp_pkg::OP_TEXT;
              in_frag = !b[7];
            end
          end
          wsfp_pkg::OP_TEXT: begin
            if (in_frag) begin
              data_ok = 1'b0;
            end else begin
              data_ok = 1'b1;
              in_frag = !b[7];
            end
          end
          wsfp_pkg::OP_CLOSE, wsfp_pkg::OP_PING, wsfp_pkg::OP_PONG: begin
            // control frames never pass payload; unfragmented only
            data_ok = 1'b0;
            if (!b[7]) op = wsfp_pkg::OP_CONT;
          end
          default: begin
            data_ok = 1'b0;
            in_frag = 1'b0;
          end
        endcase
        head_op = op;
        phase   = wsfp_pkg::PH_LEN;
      end
      wsfp_pkg::PH_LEN: begin
        if (b[6:0] == wsfp_pkg::LEN_EXT16) begin
          phase = wsfp_pkg::PH_L16A;
        end else if (b[6:0] == wsfp_pkg::LEN_EXT64) begin
          phase   = wsfp_pkg::PH_L64;
          sub_cnt = 0;
        end else begin
          frame_len = {56'd0, b[6:0]};
          phase     = wsfp_pkg::PH_KEY;
          sub_cnt   = 0;
        end
      end
      wsfp_pkg::PH_L16A: begin
        frame_len = {55'd0, b};
        phase     = wsfp_pkg::PH_L16B;
      end
      wsfp_pkg::PH_L16B: begin
        frame_len = {frame_len[54:0], b};
        phase     = wsfp_pkg::PH_KEY;
        sub_cnt   = 0;
      end
      wsfp_pkg::PH_L64: begin
        if (sub_cnt == 0) frame_len = {56'd0, b[6:0]};
        else frame_len = {frame_len[54:0], b};
        if (sub_cnt == 7) begin
          phase   = wsfp_pkg::PH_KEY;
          sub_cnt = 0;
        end else begin
          sub_cnt++;
        end
      end
      wsfp_pkg::PH_KEY: begin
        if (sub_cnt == 0 && frame_len > {31'd0, max_len}) begin
          data_ok = 1'b0;
          in_frag = 1'b0;
        end
        mask_key = {mask_key[23:0], b};
        if (sub_cnt == 3) begin
          mask_idx = 2'd0;
          sub_cnt  = 0;
          if (frame_len != 0) phase = wsfp_pkg::PH_DATA;
          else close_frame();
        end else begin
          sub_cnt++;
        end
      end
      wsfp_pkg::PH_DATA: begin
        sh = 24 - 8 * int'(mask_idx);
        if (data_ok) add_word(wsfp_pkg::KIND_DATA, b ^ mask_key[sh +: 8]);
        mask_idx  = mask_idx + 2'd1;
        frame_len = frame_len - 63'd1;
        if (frame_len == 0) close_frame();
      end
      default: phase = wsfp_pkg::PH_HEAD;
    endcase
    if (lst) add_word(wsfp_pkg::KIND_NL, wsfp_pkg::NEWLINE);
    if (expected_words.size() > base_n) expected_words[expected_words.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase     = wsfp_pkg::PH_HEAD;
      sub_cnt   = 0;
      frame_len = '0;
      mask_key  = '0;
      mask_idx  = '0;
      head_op   = wsfp_pkg::OP_CONT;
      data_ok   = 1'b1;
      in_frag   = 1'b0;
      max_len   = wsfp_pkg::MAX_LEN_RESET;
      expected_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (shown < 10)
            $display("unexpected word: kind %0d data %02h last %0b", m_tuser, m_tdata, m_tlast);
          shown++;
        end else begin
          want = expected_words.pop_front();
          if (m_tuser !== want.kind || m_tdata !== want.data || m_tlast !== want.last) begin
            errors++;
            if (shown < 10)
              $display("mismatch: expected kind %0d data %02h last %0b, %s %0d data %02h last %0b",
                       want.kind, want.data, want.last, "got kind", m_tuser, m_tdata, m_tlast);
            shown++;
          end
        end
      end
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (cfg_wen) max_len = cfg_wdata;
    end
    pending = expected_words.size();
  end

endmodule

@@ bench/tb_websocket_frame_parser.sv @@
`timescale 1ns / 100ps
// Testbench top: drives WebSocket frames into the parser and reports the verdict.
module tb_websocket_frame_parser;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF       = 400;
  localparam int RANDOM_BYTES   = 820;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_wen   = 1'b0;
  logic [31:0] cfg_wdata = 32'd0;

  int errors;
  int pending;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  bit tx_idle     = 1'b1;
  bit rx_idle     = 1'b1;
  bit hold_req    = 1'b0;

  always #4 clk = ~clk;

  websocket_frame_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  wsfp_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic pick_last();
    return $urandom_range(0, 15) == 0;
  endfunction

  task automatic send_frame(input logic [7:0] head, input logic [62:0] len, input int form);
    logic mb;
    logic top_bit;
    mb      = 1'($urandom_range(0, 1));
    top_bit = 1'($urandom_range(0, 1));
    put_byte(head, pick_last());
    case (form)
      0: put_byte({mb, len[6:0]}, pick_last());
      1: begin
        put_byte({mb, wsfp_pkg::LEN_EXT16}, pick_last());
        put_byte(len[15:8], pick_last());
        put_byte(len[7:0], pick_last());
      end
      default: begin
        put_byte({mb, wsfp_pkg::LEN_EXT64}, pick_last());
        put_byte({top_bit, len[62:56]}, pick_last());
        for (int i = 6; i >= 0; i--) put_byte(len[i * 8 +: 8], pick_last());
      end
    endcase
    repeat (4) put_byte(8'($urandom_range(0, 255)), pick_last());
    for (longint unsigned i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)), pick_last());
  endtask

  task automatic rand_frame(input logic [3:0] op, input logic fin, input int max_pay);
    logic [2:0]  rsv;
    logic [62:0] len;
    int          form;
    rsv  = 3'($urandom_range(0, 7));
    len  = 63'($urandom_range(0, max_pay));
    form = $urandom_range(0, 2);
    if (max_pay > 8 && $urandom_range(0, 24) == 0) begin
      len  = 63'($urandom_range(126, 300));
      form = $urandom_range(1, 2);
    end
    send_frame({fin, rsv, op}, len, form);
  endtask

  task automatic data_frame(input logic [3:0] op, input logic fin);
    rand_frame(op, fin, 20);
  endtask

  task automatic ctrl_frame(input logic fin);
    logic [3:0] op;
    case ($urandom_range(0, 2))
      0:       op = wsfp_pkg::OP_CLOSE;
      1:       op = wsfp_pkg::OP_PING;
      default: op = wsfp_pkg::OP_PONG;
    endcase
    rand_frame(op, fin, 6);
  endtask

  task automatic set_max_len(input logic [31:0] v);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // receiver: random back-pressure per word, one long hold-off on request
  initial begin
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int          sel;
    int          next_cfg;
    int          cfg_round;
    logic [3:0]  op;
    logic [31:0] v;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unfragmented text, two payload bytes, newline on the last
    put_byte(8'h81, 1'b0);
    put_byte(8'h82, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h5A, 1'b0);
    put_byte(8'hA5, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b1);
    // fragmented ping: dropped, no event
    put_byte(8'h09, 1'b0);
    put_byte(8'h00, 1'b0);
    repeat (4) put_byte(8'h00, 1'b0);
    // empty text starting a fragmented message, 16-bit length form
    put_byte(8'h01, 1'b0);
    put_byte(8'hFE, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    repeat (4) put_byte(8'h3C, 1'b0);
    // final continuation, 64-bit length with ignored top bit, one byte
    put_byte(8'h80, 1'b0);
    put_byte(8'h7F, 1'b0);
    put_byte(8'h80, 1'b0);
    repeat (6) put_byte(8'h00, 1'b0);
    put_byte(8'h01, 1'b0);
    repeat (4) put_byte(8'hC3, 1'b0);
    put_byte(8'h55, 1'b0);
    // close with empty payload; event and newline on one byte
    put_byte(8'h88, 1'b0);
    put_byte(8'h80, 1'b0);
    repeat (3) put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b1);

    set_max_len(32'd12);
    hold_req  = 1'b1;
    cfg_round = 0;
    next_cfg  = bytes_sent + 150;
    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent >= next_cfg) begin
        case (cfg_round)
          0: v = 32'd0;
          1: v = 32'hFFFF_FFFF;
          default: begin
            case ($urandom_range(0, 4))
              0:       v = 32'd0;
              1:       v = 32'hFFFF_FFFF;
              2:       v = wsfp_pkg::MAX_LEN_RESET;
              3:       v = $urandom_range(0, 40);
              default: v = $urandom;
            endcase
          end
        endcase
        set_max_len(v);
        cfg_round++;
        tx_idle  = $urandom_range(0, 3) != 0;
        rx_idle  = $urandom_range(0, 3) != 0;
        next_cfg = bytes_sent + 150;
      end
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        data_frame(wsfp_pkg::OP_TEXT, 1'b1);
      end else if (sel < 65) begin
        data_frame(wsfp_pkg::OP_TEXT, 1'b0);
        repeat ($urandom_range(0, 2)) begin
          if ($urandom_range(0, 3) == 0) ctrl_frame(1'b1);
          data_frame(wsfp_pkg::OP_CONT, 1'b0);
        end
        data_frame(wsfp_pkg::OP_CONT, 1'b1);
      end else if (sel < 80) begin
        ctrl_frame(1'b1);
      end else if (sel < 87) begin
        data_frame(wsfp_pkg::OP_CONT, 1'($urandom_range(0, 1)));
      end else if (sel < 92) begin
        ctrl_frame(1'b0);
      end else if (sel < 96) begin
        if ($urandom_range(0, 1) != 0) op = 4'($urandom_range(2, 7));
        else op = 4'($urandom_range(11, 15));
        data_frame(op, 1'($urandom_range(0, 1)));
      end else begin
        data_frame(wsfp_pkg::OP_TEXT, 1'b0);
        data_frame(wsfp_pkg::OP_TEXT, 1'($urandom_range(0, 1)));
      end
    end

    // oversized 64-bit length: rest of the stream is swallowed, newlines only
    put_byte(8'h81, 1'b0);
    put_byte(8'hFF, 1'b0);
    repeat (8) put_byte(8'hFF, 1'b0);
    repeat (4) put_byte(8'($urandom_range(0, 255)), 1'b0);
    repeat (40) put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
